@@ hw/rtl/rau_pkg.sv @@
// Package for the rational arithmetic unit: widths, action and status codes.
`timescale 1ns / 1ps
package rau_pkg;
    localparam int WIDTH = 32;
    localparam int DW    = 2 * WIDTH;

    typedef enum logic [3:0] {
        ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_DIV = 4'd3,
        ACT_EQ  = 4'd4, ACT_NE  = 4'd5, ACT_LT  = 4'd6, ACT_GT  = 4'd7,
        ACT_LE  = 4'd8, ACT_GE  = 4'd9
    } action_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;
endpackage

@@ hw/rtl/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: sequencer around one shared divider, multiplier and adder.
`timescale 1ns / 1ps
// Sequence: an unknown action or a zero denominator goes from the accept straight to S_OUT and the
//   strobe. Otherwise each gcd is a chain of remainder steps on the bit-serial divider, and each
//   reduction of a nonzero numerator adds its two quotients. Arithmetic also reduces its result.
// Throughput: one beat at a time; busy stays high from start until the result strobe.
// Reset: rst_n asynchronous, active low; clears the sequencer, busy and done.
// The receiver cannot stall: done is high for exactly one cycle per result.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    output logic                    done,
    input  logic [3:0]              action,
    input  logic signed [WIDTH-1:0] a_num,
    input  logic signed [WIDTH-1:0] a_den,
    input  logic signed [WIDTH-1:0] b_num,
    input  logic signed [WIDTH-1:0] b_den,
    output logic signed [WIDTH-1:0] res_num,
    output logic [WIDTH-2:0]        res_den,
    output logic                    truth,
    output logic [1:0]              status
);
    localparam int CW = $clog2(DW + 1);
    localparam logic [DW-1:0] HALF = {{(DW-WIDTH){1'b0}}, 1'b1, {(WIDTH-1){1'b0}}};

    // Sequencer states. A gcd is a chain of remainders, then two quotients.
    typedef enum logic [4:0] {
        S_IDLE, S_GA, S_GB, S_GR, S_Q1, S_Q2, S_NEXT,
        S_M1, S_M2, S_M3, S_FIN, S_OUT
    } state_t;

    state_t          state_reg;
    logic [3:0]      act_reg;
    // phase: 0 reduce a, 1 reduce b, 2 reduce result
    logic [1:0]      phase_reg;
    logic            sa_reg, sb_reg, rn_reg;
    logic [DW-1:0]   ma_reg, da_reg, mb_reg, db_reg;
    logic [DW-1:0]   xn_reg, xd_reg;          // fraction being reduced
    logic [DW-1:0]   ga_reg, gb_reg;          // Euclid pair
    logic [DW-1:0]   p_reg, q_reg;

    // Shared restoring divider: one quotient bit per cycle.
    logic [DW-1:0]   dvd_reg, dvs_reg, quo_reg, rem_reg;
    logic [CW-1:0]   cnt_reg;
    logic            dv_run_reg;
    logic [DW:0]     trial;
    assign trial = {rem_reg, dvd_reg[DW-1]} - {1'b0, dvs_reg};

    // Shared multiplier (32x32) and adder operands.
    logic [WIDTH-1:0] mx, my;
    logic [DW-1:0]    prod;
    assign prod = DW'(mx) * DW'(my);

    logic [DW-1:0] ima, ida, imb, idb;
    always_comb
    begin
        // explicit magnitudes for the most negative value
        ima = {{(DW-WIDTH){1'b0}}, (a_num[WIDTH-1] ? -a_num : a_num)};
        ida = {{(DW-WIDTH){1'b0}}, (a_den[WIDTH-1] ? -a_den : a_den)};
        imb = {{(DW-WIDTH){1'b0}}, (b_num[WIDTH-1] ? -b_num : b_num)};
        idb = {{(DW-WIDTH){1'b0}}, (b_den[WIDTH-1] ? -b_den : b_den)};
    end

    always_comb
    begin
        mx = '0;
        my = '0;
        unique case (state_reg)
            S_M1:    begin mx = ma_reg[WIDTH-1:0]; my = (act_reg == ACT_DIV || act_reg >= ACT_EQ
                         || act_reg <= ACT_SUB) ? db_reg[WIDTH-1:0] : mb_reg[WIDTH-1:0]; end
            S_M2:    begin mx = mb_reg[WIDTH-1:0]; my = da_reg[WIDTH-1:0]; end
            S_M3:    begin mx = da_reg[WIDTH-1:0];
                         my = (act_reg == ACT_DIV) ? mb_reg[WIDTH-1:0] : db_reg[WIDTH-1:0]; end
            default: ;
        endcase
    end

    logic          sbx;
    logic [DW-1:0] sum;
    logic          sum_neg;
    always_comb
    begin
        sbx = (act_reg == ACT_SUB) ? (mb_reg != '0 && !sb_reg) : sb_reg;
        sum_neg = 1'b0;
        sum = '0;
        if (sa_reg == sbx)
        begin
            sum = p_reg + q_reg; sum_neg = sa_reg;
        end
        else if (p_reg >= q_reg)
        begin
            sum = p_reg - q_reg; sum_neg = sa_reg;
        end
        else
        begin
            sum = q_reg - p_reg; sum_neg = sbx;
        end
    end

    logic cmp_t;
    always_comb
    begin
        logic signed [DW:0] cp, cq;
        cp = sa_reg ? -$signed({1'b0, p_reg}) : $signed({1'b0, p_reg});
        cq = sb_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        unique case (act_reg)
            ACT_EQ:  cmp_t = cp == cq;
            ACT_NE:  cmp_t = cp != cq;
            ACT_LT:  cmp_t = cp <  cq;
            ACT_GT:  cmp_t = cp >  cq;
            ACT_LE:  cmp_t = cp <= cq;
            default: cmp_t = cp >= cq;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done       <= 1'b0;
            dv_run_reg <= 1'b0;
            res_num    <= '0;
            res_den    <= '0;
            truth      <= 1'b0;
            status     <= ST_OK;
        end
        else
        begin
            done <= 1'b0;
            if (dv_run_reg)
            begin
                // one restoring division step
                if (!trial[DW])
                begin
                    rem_reg <= trial[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[DW-2:0], dvd_reg[DW-1]};
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
                dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    dv_run_reg <= 1'b0;
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                        if (start)
                        begin
                            act_reg   <= action;
                            sa_reg    <= a_num[WIDTH-1] ^ a_den[WIDTH-1];
                            sb_reg    <= b_num[WIDTH-1] ^ b_den[WIDTH-1];
                            ma_reg    <= ima; da_reg <= ida;
                            mb_reg    <= imb; db_reg <= idb;
                            xn_reg    <= ima; xd_reg <= ida;
                            ga_reg    <= ima; gb_reg <= ida;
                            phase_reg <= 2'd0;
                            if (action > ACT_GE)
                            begin
                                res_num <= '0; res_den <= '0; truth <= 1'b0;
                                status <= ST_OK; state_reg <= S_OUT;
                            end
                            else if (a_den == '0 || b_den == '0)
                            begin
                                res_num <= '0; res_den <= '0; truth <= 1'b0;
                                status <= ST_ZERO; state_reg <= S_OUT;
                            end
                            else
                                state_reg <= S_GA;
                        end
                    S_GA:
                        // Euclid loop head: start a % b while b nonzero
                        if (gb_reg == '0)
                        begin
                            if (xn_reg == '0)
                                state_reg <= S_NEXT;
                            else
                            begin
                                dvd_reg <= xn_reg; dvs_reg <= ga_reg;
                                rem_reg <= '0; quo_reg <= '0;
                                cnt_reg <= CW'(DW); dv_run_reg <= 1'b1;
                                state_reg <= S_Q1;
                            end
                        end
                        else
                        begin
                            dvd_reg <= ga_reg; dvs_reg <= gb_reg;
                            rem_reg <= '0; quo_reg <= '0;
                            cnt_reg <= CW'(DW); dv_run_reg <= 1'b1;
                            state_reg <= S_GR;
                        end
                    S_GR:
                    begin
                        ga_reg <= gb_reg; gb_reg <= rem_reg; state_reg <= S_GA;
                    end
                    S_Q1:
                    begin
                        xn_reg <= quo_reg;
                        dvd_reg <= xd_reg; dvs_reg <= ga_reg;
                        rem_reg <= '0; quo_reg <= '0;
                        cnt_reg <= CW'(DW); dv_run_reg <= 1'b1;
                        state_reg <= S_Q2;
                    end
                    S_Q2:
                    begin
                        xd_reg <= quo_reg; state_reg <= S_NEXT;
                    end
                    S_NEXT:
                        unique case (phase_reg)
                            2'd0:
                            begin
                                ma_reg <= xn_reg;
                                da_reg <= (xn_reg == '0) ? DW'(1) : xd_reg;
                                if (xn_reg == '0) sa_reg <= 1'b0;
                                xn_reg <= mb_reg; xd_reg <= db_reg;
                                ga_reg <= mb_reg; gb_reg <= db_reg;
                                phase_reg <= 2'd1; state_reg <= S_GA;
                            end
                            2'd1:
                            begin
                                mb_reg <= xn_reg;
                                db_reg <= (xn_reg == '0) ? DW'(1) : xd_reg;
                                if (xn_reg == '0) sb_reg <= 1'b0;
                                if (act_reg == ACT_DIV && xn_reg == '0)
                                begin
                                    res_num <= '0; res_den <= '0; truth <= 1'b0;
                                    status <= ST_ZERO; state_reg <= S_OUT;
                                end
                                else
                                    state_reg <= S_M1;
                            end
                            default:
                                state_reg <= S_FIN;
                        endcase
                    S_M1:
                    begin
                        p_reg <= prod; state_reg <= S_M2;
                    end
                    S_M2:
                    begin
                        q_reg <= prod; state_reg <= S_M3;
                    end
                    S_M3:
                    begin
                        if (act_reg >= ACT_EQ)
                        begin
                            res_num <= '0; res_den <= '0; truth <= cmp_t;
                            status <= ST_OK; state_reg <= S_OUT;
                        end
                        else
                        begin
                            if (act_reg <= ACT_SUB)
                            begin
                                xn_reg <= sum; rn_reg <= sum_neg && (sum != '0);
                                ga_reg <= sum;
                            end
                            else
                            begin
                                // mul uses p = ma*mb, div uses p = ma*db
                                xn_reg <= p_reg; ga_reg <= p_reg;
                                rn_reg <= (p_reg != '0) && (sa_reg != sb_reg);
                            end
                            xd_reg <= prod; gb_reg <= prod;
                            phase_reg <= 2'd2; state_reg <= S_GA;
                        end
                    end
                    S_FIN:
                    begin
                        logic [DW-1:0] rd;
                        logic          neg;
                        rd  = (xn_reg == '0) ? DW'(1) : xd_reg;
                        neg = rn_reg && (xn_reg != '0);
                        truth <= 1'b0;
                        if ((neg ? xn_reg > HALF : xn_reg >= HALF) || rd >= HALF)
                        begin
                            res_num <= '0; res_den <= '0; status <= ST_OVF;
                        end
                        else
                        begin
                            res_num <= neg ? -xn_reg[WIDTH-1:0] : xn_reg[WIDTH-1:0];
                            res_den <= rd[WIDTH-2:0]; status <= ST_OK;
                        end
                        state_reg <= S_OUT;
                    end
                    S_OUT:
                    begin
                        done <= 1'b1; state_reg <= S_IDLE;
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !dv_run_reg) |=> (done && state_reg == S_IDLE))
        else $error("result strobe missing");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("strobe longer than one cycle");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !dv_run_reg) else $error("divider running while idle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("beat not taken");
endmodule

@@ dv/rational_arithmetic_unit_tb.sv @@
// Testbench for the rational arithmetic unit: directed and random fractions, self-checking.
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int          N_RANDOM    = 1500;
    localparam int          CALM_TAIL   = 200;       // last beats sent back to back
    localparam longint      CYCLE_LIMIT = 64'd60_000_000;
    localparam longint unsigned HALF    = 64'd1 << (WIDTH - 1);

    typedef struct {
        logic [3:0]              action;
        logic signed [WIDTH-1:0] a_num, a_den, b_num, b_den;
        bit                      drain;              // hold off until all results are back
    } frac_op_t;

    typedef struct {
        logic signed [WIDTH-1:0] num;
        logic [WIDTH-2:0]        den;
        logic                    truth;
        logic [1:0]              status;
    } frac_res_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy, done;
    logic [3:0]              action = '0;
    logic signed [WIDTH-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
    logic signed [WIDTH-1:0] res_num;
    logic [WIDTH-2:0]        res_den;
    logic                    truth;
    logic [1:0]              status;

    frac_op_t  pending_ops[$];
    frac_res_t expected_res[$];
    int        n_errors = 0;
    int        n_sent = 0;
    int        n_checked = 0;
    int        n_by_status[4] = '{0, 0, 0, 0};
    int        gap_left = 0;
    longint    cycles = 0;

    always #10 clk = ~clk;

    rational_arithmetic_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .action(action), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .res_num(res_num), .res_den(res_den), .truth(truth), .status(status)
    );

    // ---------------------------------------------------------------------
    // Predictor: Euclid on 64-bit magnitudes, sign carried separately
    // ---------------------------------------------------------------------
    function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Reduce n/d (d nonzero); zero numerator becomes 0/1
    function automatic void reduce_frac(input longint n, input longint d, output bit neg,
                                        output longint unsigned mag,
                                        output longint unsigned den);
        longint unsigned mn, md, g;
        mn  = (n < 0) ? longint'(0) - n : n;
        md  = (d < 0) ? longint'(0) - d : d;
        g   = euclid(mn, md);
        mag = mn / g;
        den = md / g;
        neg = (mag != 0) && ((n < 0) != (d < 0));
        if (mag == 0)
            den = 1;
    endfunction

    function automatic frac_res_t rational_result(frac_op_t op);
        frac_res_t       r;
        bit              sa, sb, rn, sb_eff;
        longint unsigned ma, da, mb, db, rm, rd, g, p1, p2;
        longint          p, q;
        r = '{num: '0, den: '0, truth: 1'b0, status: ST_OK};
        if (op.action > ACT_GE)
            return r;
        if (op.a_den == 0 || op.b_den == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        reduce_frac(longint'(op.a_num), longint'(op.a_den), sa, ma, da);
        reduce_frac(longint'(op.b_num), longint'(op.b_den), sb, mb, db);

        if (op.action >= ACT_EQ) begin
            p = sa ? -longint'(ma * db) : longint'(ma * db);
            q = sb ? -longint'(mb * da) : longint'(mb * da);
            case (op.action)
                ACT_EQ:  r.truth = (p == q);
                ACT_NE:  r.truth = (p != q);
                ACT_LT:  r.truth = (p < q);
                ACT_GT:  r.truth = (p > q);
                ACT_LE:  r.truth = (p <= q);
                default: r.truth = (p >= q);
            endcase
            return r;
        end

        case (op.action)
            ACT_ADD, ACT_SUB: begin
                // subtraction flips the sign of a nonzero right operand
                sb_eff = (op.action == ACT_SUB) ? (mb != 0 && !sb) : sb;
                p1 = ma * db;
                p2 = mb * da;
                if (sa == sb_eff) begin
                    rn = sa;
                    rm = p1 + p2;
                end else if (p1 >= p2) begin
                    rn = sa;
                    rm = p1 - p2;
                end else begin
                    rn = sb_eff;
                    rm = p2 - p1;
                end
                rd = da * db;
            end
            ACT_MUL: begin
                rm = ma * mb;
                rn = (rm != 0) && (sa != sb);
                rd = da * db;
            end
            default: begin
                if (mb == 0) begin
                    r.status = ST_ZERO;
                    return r;
                end
                rm = ma * db;
                rn = (rm != 0) && (sa != sb);
                rd = da * mb;
            end
        endcase

        if (rm == 0) begin
            rd = 1;
            rn = 1'b0;
        end else begin
            g  = euclid(rm, rd);
            rm = rm / g;
            rd = rd / g;
        end
        // negative side of the range reaches one step further
        if ((rn ? rm > HALF : rm >= HALF) || rd >= HALF) begin
            r.status = ST_OVF;
            return r;
        end
        r.num = rn ? WIDTH'(-rm) : WIDTH'(rm);
        r.den = rd[WIDTH-2:0];
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    function automatic logic signed [WIDTH-1:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            return $urandom_range(0, 40) - 20;                // small, gcd-rich
        if (sel < 50) begin
            case ($urandom_range(0, 6))
                0: return 0;
                1: return 1;
                2: return -1;
                3: return {1'b0, {(WIDTH-1){1'b1}}};
                4: return {1'b1, {(WIDTH-1){1'b0}}};
                5: return {1'b0, {(WIDTH-2){1'b1}}, 1'b0};
                default: return {1'b1, {(WIDTH-2){1'b0}}, 1'b1};
            endcase
        end
        if (sel < 70)
            return $urandom_range(0, 65535) - 32768;          // mid range, fits mostly
        return $urandom;
    endfunction

    function automatic frac_op_t mk_op(logic [3:0] act, int an, int ad, int bn, int bd);
        frac_op_t op;
        op = '{action: act, a_num: an, a_den: ad, b_num: bn, b_den: bd, drain: 1'b0};
        return op;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: one beat in flight at most; start is assigned once per edge
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        frac_op_t op;
        logic     start_nxt;
        bit       accepted;
        if (!rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            accepted  = start && !busy;
            start_nxt = start && !accepted;
            if (accepted) begin
                expected_res.push_back(rational_result('{action: action, a_num: a_num,
                    a_den: a_den, b_num: b_num, b_den: b_den, drain: 1'b0}));
                n_sent = n_sent + 1;
                // random idle burst, none in the calm tail
                if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
                    gap_left <= $urandom_range(1, 10);
            end
            if (!start_nxt) begin
                if (gap_left > 0 && !accepted) begin
                    // the idle burst counts only once the unit is free again
                    if (!busy)
                        gap_left <= gap_left - 1;
                end
                else if (!accepted && pending_ops.size() != 0 &&
                         (!pending_ops[0].drain || expected_res.size() == 0)) begin
                    op        = pending_ops.pop_front();
                    action    <= op.action;
                    a_num     <= op.a_num;
                    a_den     <= op.a_den;
                    b_num     <= op.b_num;
                    b_den     <= op.b_den;
                    start_nxt = 1'b1;
                end
            end
            start <= start_nxt;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: done lasts one cycle, sample it at the edge that ends it
    // ---------------------------------------------------------------------
    always @(posedge clk) begin
        frac_res_t want;
        if (rst_n && done) begin
            if (expected_res.size() == 0) begin
                n_errors = n_errors + 1;
                if (n_errors <= 10)
                    $display("ERROR: result with nothing pending: %0d/%0d t=%0b s=%0d",
                             res_num, res_den, truth, status);
            end else begin
                want = expected_res.pop_front();
                n_checked = n_checked + 1;
                n_by_status[want.status] = n_by_status[want.status] + 1;
                if (res_num !== want.num || res_den !== want.den ||
                    truth !== want.truth || status !== want.status) begin
                    n_errors = n_errors + 1;
                    if (n_errors <= 10)
                        $display("ERROR: beat %0d got %0d/%0d t=%0b s=%0d, want %0d/%0d t=%0b s=%0d",
                                 n_checked, res_num, res_den, truth, status,
                                 want.num, want.den, want.truth, want.status);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results pending", cycles,
                     expected_res.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial begin
        frac_op_t op;
        int       min_i, max_i;
        min_i = {1'b1, {(WIDTH-1){1'b0}}};
        max_i = {1'b0, {(WIDTH-1){1'b1}}};

        // directed: every action, the error paths and the range edges
        pending_ops.push_back(mk_op(ACT_ADD, 1, 2, 1, 3));
        pending_ops.push_back(mk_op(ACT_SUB, 1, 2, 1, 3));
        pending_ops.push_back(mk_op(ACT_SUB, 1, 3, 1, 3));       // zero result -> 0/1
        pending_ops.push_back(mk_op(ACT_MUL, -2, 3, 3, -4));
        pending_ops.push_back(mk_op(ACT_DIV, 2, -3, -4, 9));
        pending_ops.push_back(mk_op(ACT_EQ, 2, 4, -3, -6));
        pending_ops.push_back(mk_op(ACT_NE, 2, 4, 1, 3));
        pending_ops.push_back(mk_op(ACT_LT, -1, 2, 1, 3));
        pending_ops.push_back(mk_op(ACT_GT, -1, 2, 1, 3));
        pending_ops.push_back(mk_op(ACT_LE, 5, 10, 1, 2));
        pending_ops.push_back(mk_op(ACT_GE, min_i, 1, max_i, 1));
        pending_ops.push_back(mk_op(ACT_ADD, 1, 0, 1, 1));        // zero left denominator
        pending_ops.push_back(mk_op(ACT_LT, 1, 1, 1, 0));         // zero right denominator
        pending_ops.push_back(mk_op(ACT_DIV, 3, 7, 0, -5));       // divide by zero fraction
        pending_ops.push_back(mk_op(ACT_ADD, max_i, 1, 1, 1));    // numerator too wide
        pending_ops.push_back(mk_op(ACT_MUL, min_i, 1, 1, 1));    // most negative still fits
        pending_ops.push_back(mk_op(ACT_MUL, min_i, -1, 1, 1));   // positive 2^31 overflows
        pending_ops.push_back(mk_op(ACT_DIV, 1, min_i, 1, 1));    // denominator too wide
        pending_ops.push_back(mk_op(ACT_MUL, max_i, min_i, min_i, max_i));
        pending_ops.push_back(mk_op(ACT_ADD, 0, 5, 0, -3));
        pending_ops.push_back(mk_op(ACT_SUB, min_i, min_i, max_i, max_i));
        pending_ops.push_back(mk_op(4'd10, 1, 2, 3, 4));          // unknown actions
        pending_ops.push_back(mk_op(4'd15, -1, -1, -1, -1));
        pending_ops.push_back(mk_op(ACT_DIV, -7, -14, 3, -6));

        for (int i = 0; i < N_RANDOM; i++) begin
            op.action = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                     : 4'($urandom_range(0, 9));
            op.a_num = pick_operand();
            op.b_num = pick_operand();
            op.a_den = pick_operand();
            op.b_den = pick_operand();
            // keep denominators mostly nonzero so the arithmetic gets exercised
            if (op.a_den == 0 && $urandom_range(0, 3) != 0)
                op.a_den = $urandom_range(1, 9);
            if (op.b_den == 0 && $urandom_range(0, 3) != 0)
                op.b_den = $urandom_range(1, 9);
            // sender waits for the unit to drain now and then
            op.drain = (i % 300 == 150);
            pending_ops.push_back(op);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || start || expected_res.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d beats over all ten actions and unknown codes; checked %0d results",
                 n_sent, n_checked);
        $display("Outcomes: %0d ok, %0d zero-denominator, %0d overflow",
                 n_by_status[ST_OK], n_by_status[ST_ZERO], n_by_status[ST_OVF]);
        if (n_errors == 0 && expected_res.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/rau_pkg.sv
hw/rtl/rational_arithmetic_unit.sv
dv/rational_arithmetic_unit_tb.sv
